>>> rtl/egvf_pkg.sv
// ----------------------------------------------------------------------------
// egvf_pkg
// Shared types and constants of the ellipse guidance vector field block.
// ----------------------------------------------------------------------------
`default_nettype none

package egvf_pkg;

    // query point, Q16.16 metres
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_in;

    // unit guidance vector, Q1.14
    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic               zero_field;
    } t_out;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_ROT   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_ROT   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_A_SQ  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_B_SQ  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 4'd7;

    localparam logic [14:0] UNIT_Q14 = 15'd16384;

endpackage

`default_nettype wire

>>> rtl/ellipse_guidance_vector_field.sv
// ----------------------------------------------------------------------------
// ellipse_guidance_vector_field
// Unit guidance vector of the guiding vector field of a rotated ellipse.
// ----------------------------------------------------------------------------
// Pipeline: the done strobe and its result pass through 16 arithmetic stages, a root
// entry plus 31 root-bit stages, a divider entry plus 16 quotient-bit stages and
// the output register.
// Throughput: one transaction per cycle; busy is never raised and no stage stalls.
// Reset (synchronous, active low) drops all in-flight transactions and loads
// the register reset values.
`default_nettype none

module ellipse_guidance_vector_field #(
    parameter int COORD_WIDTH = 32
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  egvf_pkg::t_in                         i_in,
    output logic                                  o_done,
    output egvf_pkg::t_out                        o_result,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [egvf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [egvf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int W  = COORD_WIDTH;
    // wide enough for any exact product used below, plus rounding headroom
    localparam int PW = ((2 * W > W + 33) ? 2 * W : W + 33) + 2;
    // multiplier operand width: a coordinate or a 32 bit unsigned register
    localparam int MW = ((W > 32) ? W : 32) + 1;
    localparam int PB = $clog2(W);
    localparam int RS = 31;   // root bits
    localparam int QS = 16;   // quotient bits

    localparam logic signed [PW-1:0] SMAX_P = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] ONE_P  = (W >= 18) ? PW'(65536) : SMAX_P;

    typedef struct packed {
        logic [29:0] mx;
        logic [29:0] my;
        logic        sx;
        logic        sy;
        logic        zero;
    } t_side;

    // ------------------------------------------------------------------
    // Saturating helpers
    // ------------------------------------------------------------------
    function automatic logic signed [W-1:0] clampp(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] r;
        if (v > SMAX_P)       r = SMAX_P;
        else if (v < -SMAX_P) r = -SMAX_P;
        else                  r = v;
        return r[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        return clampp(PW'(a) + PW'(b));
    endfunction

    // shift an exact product right, rounding half away from zero, saturate
    function automatic logic signed [W-1:0] rsat(input logic signed [PW-1:0] p,
                                                 input int sh);
        logic [PW-1:0]        mg;
        logic [PW-1:0]        hf;
        logic [PW-1:0]        q;
        logic signed [PW-1:0] r;
        mg = p[PW-1] ? PW'(-p) : PW'(p);
        hf = PW'(1) << (sh - 1);
        q  = (mg + hf) >> sh;
        if (q > PW'(SMAX_P)) q = PW'(SMAX_P);
        r = signed'(q);
        if (p[PW-1]) r = -r;
        return r[W-1:0];
    endfunction

    function automatic logic signed [PW-1:0] mulp(input logic signed [MW-1:0] a,
                                                  input logic signed [MW-1:0] b);
        logic signed [2*MW-1:0] p;
        p = a * b;
        return PW'(p);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0] r_center_x, r_center_y;
    logic signed [15:0] r_cos, r_sin;
    logic [31:0]        r_inv_a, r_inv_b;
    logic               r_dir;
    logic [15:0]        r_gain;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_cos      <= 16'sd16384;
            r_sin      <= '0;
            r_inv_a    <= 32'h8000_0000;
            r_inv_b    <= 32'h8000_0000;
            r_dir      <= 1'b0;
            r_gain     <= 16'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                egvf_pkg::CFG_CENTER_X:  r_center_x <= i_cfg_data;
                egvf_pkg::CFG_CENTER_Y:  r_center_y <= i_cfg_data;
                egvf_pkg::CFG_COS_ROT:   r_cos      <= i_cfg_data[15:0];
                egvf_pkg::CFG_SIN_ROT:   r_sin      <= i_cfg_data[15:0];
                egvf_pkg::CFG_INV_A_SQ:  r_inv_a    <= i_cfg_data;
                egvf_pkg::CFG_INV_B_SQ:  r_inv_b    <= i_cfg_data;
                egvf_pkg::CFG_DIRECTION: r_dir      <= i_cfg_data[0];
                egvf_pkg::CFG_GAIN:      r_gain     <= i_cfg_data[15:0];
                default: ;   // drop writes beyond the register list
            endcase
        end
    end

    // widened multiplicands from the registers
    logic signed [MW-1:0] w_c, w_s, w_ia, w_ib, w_g;
    assign w_c  = MW'(r_cos);
    assign w_s  = MW'(r_sin);
    assign w_ia = MW'({1'b0, r_inv_a});
    assign w_ib = MW'({1'b0, r_inv_b});
    assign w_g  = MW'({1'b0, r_gain});

    // ------------------------------------------------------------------
    // Arithmetic pipe, stages 1 to 12: field vector in Q.16
    // ------------------------------------------------------------------
    logic [16:1]          r_vld;
    logic signed [W-1:0]  r1_dx, r1_dy;
    logic signed [PW-1:0] r2_p [0:3];
    logic signed [W-1:0]  r3_xel, r3_yel;
    logic signed [PW-1:0] r4_pa, r4_pb;
    logic signed [W-1:0]  r4_xel, r4_yel;
    logic signed [W-1:0]  r5_ux, r5_uy, r5_gx, r5_gy, r5_xel, r5_yel;
    logic signed [PW-1:0] r6_p [0:5];
    logic signed [W-1:0]  r7_nx, r7_ny, r7_es;
    logic signed [W-1:0]  r8_e, r8_tx, r8_ty, r8_nx, r8_ny;
    logic signed [PW-1:0] r9_pk;
    logic signed [W-1:0]  r9_tx, r9_ty, r9_nx, r9_ny;
    logic signed [W-1:0]  r10_ke, r10_tx, r10_ty, r10_nx, r10_ny;
    logic signed [PW-1:0] r11_px, r11_py;
    logic signed [W-1:0]  r11_tx, r11_ty;
    logic signed [W-1:0]  r12_vx, r12_vy;

    // stages 13 to 16: magnitudes, normalisation, sum of squares
    logic [W-2:0]         r13_mx, r13_my, r13_m;
    logic                 r13_sx, r13_sy, r13_zero;
    logic [W-2:0]         r14_mx, r14_my;
    logic [PB-1:0]        r14_p;
    logic                 r14_sx, r14_sy, r14_zero;
    t_side                r15_sd, r16_sd;
    logic [59:0]          r16_qx, r16_qy;

    logic signed [W-1:0]  n5_ux, n5_uy;
    logic [W-2:0]         n13_mx, n13_my;
    logic [PB-1:0]        n14_p;
    logic [W+27:0]        n15_ex, n15_ey;

    assign n5_ux  = rsat(r4_pa, 31);
    assign n5_uy  = rsat(r4_pb, 31);
    assign n13_mx = r12_vx[W-1] ? (W-1)'(-r12_vx) : r12_vx[W-2:0];
    assign n13_my = r12_vy[W-1] ? (W-1)'(-r12_vy) : r12_vy[W-2:0];

    // leading one of the larger magnitude
    always_comb begin
        n14_p = '0;
        for (int i = 0; i < W - 1; i++) begin
            if (r13_m[i]) n14_p = PB'(i);
        end
    end

    // move the leading one to bit 29; right shifts truncate
    assign n15_ex = {r14_mx, 29'd0} >> r14_p;
    assign n15_ey = {r14_my, 29'd0} >> r14_p;

    // ------------------------------------------------------------------
    // Square root: one root bit per stage, remainder kept as v - root^2
    // ------------------------------------------------------------------
    logic [63:0] r_q_rem  [0:RS];
    logic [30:0] r_q_root [0:RS];
    t_side       r_q_sd   [0:RS];
    logic [RS:0] r_q_vld;
    logic [63:0] n_q_rem  [0:RS-1];
    logic [30:0] n_q_root [0:RS-1];

    always_comb begin
        for (int s = 0; s < RS; s++) begin
            logic [63:0] t;
            t = ({33'd0, r_q_root[s]} << (RS - s)) + (64'd1 << (2 * (RS - 1 - s)));
            if (r_q_rem[s] >= t) begin
                n_q_rem[s]  = r_q_rem[s] - t;
                n_q_root[s] = r_q_root[s] | (31'd1 << (RS - 1 - s));
            end else begin
                n_q_rem[s]  = r_q_rem[s];
                n_q_root[s] = r_q_root[s];
            end
        end
    end

    // ------------------------------------------------------------------
    // Dividers: one quotient bit per stage, x and y side by side
    // ------------------------------------------------------------------
    logic [47:0] r_d_rx  [0:QS];
    logic [47:0] r_d_ry  [0:QS];
    logic [15:0] r_d_qx  [0:QS];
    logic [15:0] r_d_qy  [0:QS];
    logic [30:0] r_d_len [0:QS];
    t_side       r_d_sd  [0:QS];
    logic [QS:0] r_d_vld;
    logic [47:0] n_d_rx  [0:QS-1];
    logic [47:0] n_d_ry  [0:QS-1];
    logic [15:0] n_d_qx  [0:QS-1];
    logic [15:0] n_d_qy  [0:QS-1];

    always_comb begin
        for (int j = 0; j < QS; j++) begin
            logic [47:0] dk;
            dk = {17'd0, r_d_len[j]} << (QS - 1 - j);
            n_d_rx[j] = r_d_rx[j];
            n_d_qx[j] = r_d_qx[j];
            n_d_ry[j] = r_d_ry[j];
            n_d_qy[j] = r_d_qy[j];
            if (r_d_rx[j] >= dk) begin
                n_d_rx[j] = r_d_rx[j] - dk;
                n_d_qx[j] = r_d_qx[j] | (16'd1 << (QS - 1 - j));
            end
            if (r_d_ry[j] >= dk) begin
                n_d_ry[j] = r_d_ry[j] - dk;
                n_d_qy[j] = r_d_qy[j] | (16'd1 << (QS - 1 - j));
            end
        end
    end

    // final rounding clamp and sign
    logic [14:0] n_ox, n_oy;
    assign n_ox = (r_d_qx[QS] > 16'(egvf_pkg::UNIT_Q14)) ? egvf_pkg::UNIT_Q14
                                                        : r_d_qx[QS][14:0];
    assign n_oy = (r_d_qy[QS] > 16'(egvf_pkg::UNIT_Q14)) ? egvf_pkg::UNIT_Q14
                                                        : r_d_qy[QS][14:0];

    // ------------------------------------------------------------------
    // Valid bits travel with the data; reset drops everything in flight
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= '0;
            r_d_vld <= '0;
            o_done  <= 1'b0;
        end else begin
            r_vld   <= {r_vld[15:1], start && !busy};
            r_q_vld <= {r_q_vld[RS-1:0], r_vld[16]};
            r_d_vld <= {r_d_vld[QS-1:0], r_q_vld[RS]};
            o_done  <= r_d_vld[QS];
        end
    end

    // ------------------------------------------------------------------
    // Payload: advance every cycle, no reset needed
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        // offset from the centre
        r1_dx <= clampp(PW'(i_in.point_x) - PW'(r_center_x));
        r1_dy <= clampp(PW'(i_in.point_y) - PW'(r_center_y));
        // rotate into the ellipse frame
        r2_p[0] <= mulp(MW'(r1_dx), w_c);
        r2_p[1] <= mulp(MW'(r1_dy), w_s);
        r2_p[2] <= mulp(MW'(r1_dx), w_s);
        r2_p[3] <= mulp(MW'(r1_dy), w_c);
        r3_xel  <= sadd(rsat(r2_p[0], 14), -rsat(r2_p[1], 14));
        r3_yel  <= sadd(rsat(r2_p[2], 14), rsat(r2_p[3], 14));
        // scale by the reciprocal squared semi-axes
        r4_pa   <= mulp(MW'(r3_xel), w_ia);
        r4_pb   <= mulp(MW'(r3_yel), w_ib);
        r4_xel  <= r3_xel;
        r4_yel  <= r3_yel;
        r5_ux   <= n5_ux;
        r5_uy   <= n5_uy;
        r5_gx   <= sadd(n5_ux, n5_ux);
        r5_gy   <= sadd(n5_uy, n5_uy);
        r5_xel  <= r4_xel;
        r5_yel  <= r4_yel;
        // rotate the gradient back, form the level error
        r6_p[0] <= mulp(MW'(r5_gx), w_c);
        r6_p[1] <= mulp(MW'(r5_gy), w_s);
        r6_p[2] <= mulp(MW'(r5_gx), w_s);
        r6_p[3] <= mulp(MW'(r5_gy), w_c);
        r6_p[4] <= mulp(MW'(r5_ux), MW'(r5_xel));
        r6_p[5] <= mulp(MW'(r5_uy), MW'(r5_yel));
        r7_nx   <= sadd(rsat(r6_p[0], 14), rsat(r6_p[1], 14));
        r7_ny   <= sadd(-rsat(r6_p[2], 14), rsat(r6_p[3], 14));
        r7_es   <= sadd(rsat(r6_p[4], 16), rsat(r6_p[5], 16));
        r8_e    <= clampp(PW'(r7_es) - ONE_P);
        r8_tx   <= r_dir ? -r7_ny : r7_ny;
        r8_ty   <= r_dir ? r7_nx : -r7_nx;
        r8_nx   <= r7_nx;
        r8_ny   <= r7_ny;
        // gain times error
        r9_pk   <= mulp(w_g, MW'(r8_e));
        r9_tx   <= r8_tx;
        r9_ty   <= r8_ty;
        r9_nx   <= r8_nx;
        r9_ny   <= r8_ny;
        r10_ke  <= rsat(r9_pk, 8);
        r10_tx  <= r9_tx;
        r10_ty  <= r9_ty;
        r10_nx  <= r9_nx;
        r10_ny  <= r9_ny;
        r11_px  <= mulp(MW'(r10_ke), MW'(r10_nx));
        r11_py  <= mulp(MW'(r10_ke), MW'(r10_ny));
        r11_tx  <= r10_tx;
        r11_ty  <= r10_ty;
        r12_vx  <= sadd(r11_tx, -rsat(r11_px, 16));
        r12_vy  <= sadd(r11_ty, -rsat(r11_py, 16));
        // magnitudes and the larger of the two
        r13_mx   <= n13_mx;
        r13_my   <= n13_my;
        r13_m    <= (n13_mx > n13_my) ? n13_mx : n13_my;
        r13_sx   <= r12_vx[W-1];
        r13_sy   <= r12_vy[W-1];
        r13_zero <= (r12_vx == '0) && (r12_vy == '0);
        r14_mx   <= r13_mx;
        r14_my   <= r13_my;
        r14_p    <= n14_p;
        r14_sx   <= r13_sx;
        r14_sy   <= r13_sy;
        r14_zero <= r13_zero;
        r15_sd   <= '{mx: n15_ex[29:0], my: n15_ey[29:0],
                      sx: r14_sx, sy: r14_sy, zero: r14_zero};
        r16_qx   <= r15_sd.mx * r15_sd.mx;
        r16_qy   <= r15_sd.my * r15_sd.my;
        r16_sd   <= r15_sd;
        // enter the square root
        r_q_rem[0]  <= {4'd0, r16_qx} + {4'd0, r16_qy};
        r_q_root[0] <= '0;
        r_q_sd[0]   <= r16_sd;
        for (int s = 0; s < RS; s++) begin
            r_q_rem[s+1]  <= n_q_rem[s];
            r_q_root[s+1] <= n_q_root[s];
            r_q_sd[s+1]   <= r_q_sd[s];
        end
        // enter the dividers: (m * 2^14 + len/2) / len
        r_d_rx[0]  <= {4'd0, r_q_sd[RS].mx, 14'd0} + {18'd0, r_q_root[RS][30:1]};
        r_d_ry[0]  <= {4'd0, r_q_sd[RS].my, 14'd0} + {18'd0, r_q_root[RS][30:1]};
        r_d_qx[0]  <= '0;
        r_d_qy[0]  <= '0;
        r_d_len[0] <= r_q_root[RS];
        r_d_sd[0]  <= r_q_sd[RS];
        for (int j = 0; j < QS; j++) begin
            r_d_rx[j+1]  <= n_d_rx[j];
            r_d_ry[j+1]  <= n_d_ry[j];
            r_d_qx[j+1]  <= n_d_qx[j];
            r_d_qy[j+1]  <= n_d_qy[j];
            r_d_len[j+1] <= r_d_len[j];
            r_d_sd[j+1]  <= r_d_sd[j];
        end
        // result register; a zero field forces zero outputs
        if (r_d_sd[QS].zero) begin
            o_result <= '{dir_x: '0, dir_y: '0, zero_field: 1'b1};
        end else begin
            o_result.dir_x      <= r_d_sd[QS].sx ? -$signed({1'b0, n_ox})
                                                 : $signed({1'b0, n_ox});
            o_result.dir_y      <= r_d_sd[QS].sy ? -$signed({1'b0, n_oy})
                                                 : $signed({1'b0, n_oy});
            o_result.zero_field <= 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> test/tb_ellipse_guidance_vector_field.sv
// ----------------------------------------------------------------------------
// tb_ellipse_guidance_vector_field
// Self-checking bench: query points go in through the start/busy handshake,
// a behavioural model of the rotated-ellipse guidance field predicts each unit
// vector, and every strobed result is matched in order against the prediction.
// Register settings change between phases while the pipe is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ellipse_guidance_vector_field;

    localparam longint SAT    = 64'sd2147483647;
    localparam longint ONE_Q16 = 64'sd65536;
    localparam int     DRAIN  = 80;   // pipe is 66 deep; allow some slack

    // Expected-vector store with its own copy of the field registers
    class field_scoreboard;
        longint cx, cy, c, s, ia, ib, gain;
        bit     dir;
        egvf_pkg::t_out vec_q[$];
        int     errors;

        function new();
            cx = 0; cy = 0; c = 16384; s = 0;
            ia = 64'sd2147483648; ib = 64'sd2147483648;
            dir = 0; gain = 256; errors = 0;
        endfunction

        function void write_reg(logic [egvf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
            case (idx)
                egvf_pkg::CFG_CENTER_X:  cx = longint'($signed(d));
                egvf_pkg::CFG_CENTER_Y:  cy = longint'($signed(d));
                egvf_pkg::CFG_COS_ROT:   c = longint'($signed(d[15:0]));
                egvf_pkg::CFG_SIN_ROT:   s = longint'($signed(d[15:0]));
                egvf_pkg::CFG_INV_A_SQ:  ia = longint'({32'b0, d});
                egvf_pkg::CFG_INV_B_SQ:  ib = longint'({32'b0, d});
                egvf_pkg::CFG_DIRECTION: dir = d[0];
                egvf_pkg::CFG_GAIN:      gain = longint'({48'b0, d[15:0]});
                default: ;
            endcase
        endfunction

        function longint clamp(longint v);
            if (v > SAT) return SAT;
            if (v < -SAT) return -SAT;
            return v;
        endfunction

        function longint sat_add(longint a, longint b);
            return clamp(clamp(a) + clamp(b));
        endfunction

        // exact product, shift back rounding half away from zero, saturate
        function longint mul_round(longint x, longint y, int sh);
            logic [127:0] a, b, p;
            longint       r;
            a = (x < 0) ? 128'(-x) : 128'(x);
            b = (y < 0) ? 128'(-y) : 128'(y);
            p = (a * b + (128'd1 << (sh - 1))) >> sh;
            r = (p > 128'(SAT)) ? SAT : longint'(p);
            return ((x < 0) != (y < 0)) ? -r : r;
        endfunction

        function logic [63:0] floor_sqrt(logic [63:0] v);
            logic [63:0] res, bt;
            res = 0;
            bt = 64'd1 << 62;
            while (bt > v) bt >>= 2;
            while (bt != 0) begin
                if (v >= res + bt) begin
                    v -= res + bt;
                    res = (res >> 1) + bt;
                end else begin
                    res >>= 1;
                end
                bt >>= 2;
            end
            return res;
        endfunction

        function egvf_pkg::t_out field_vector(egvf_pkg::t_in p);
            longint dx, dy, xel, yel, ux, uy, gx, gy, nx, ny, e, tx, ty, ke, vx, vy;
            logic [63:0] mx, my, m, len, ox, oy;
            egvf_pkg::t_out r;
            dx  = clamp(longint'(p.point_x) - cx);
            dy  = clamp(longint'(p.point_y) - cy);
            xel = sat_add(mul_round(dx, c, 14), -mul_round(dy, s, 14));
            yel = sat_add(mul_round(dx, s, 14), mul_round(dy, c, 14));
            ux  = mul_round(xel, ia, 31);
            uy  = mul_round(yel, ib, 31);
            gx  = sat_add(ux, ux);
            gy  = sat_add(uy, uy);
            nx  = sat_add(mul_round(gx, c, 14), mul_round(gy, s, 14));
            ny  = sat_add(-mul_round(gx, s, 14), mul_round(gy, c, 14));
            e   = sat_add(sat_add(mul_round(ux, xel, 16), mul_round(uy, yel, 16)), -ONE_Q16);
            tx  = dir ? -ny : ny;
            ty  = dir ? nx : -nx;
            ke  = mul_round(gain, e, 8);
            vx  = sat_add(tx, -mul_round(ke, nx, 16));
            vy  = sat_add(ty, -mul_round(ke, ny, 16));
            r = '0;
            if (vx == 0 && vy == 0) begin
                r.zero_field = 1'b1;
                return r;
            end
            mx = (vx < 0) ? -vx : vx;
            my = (vy < 0) ? -vy : vy;
            m  = (mx > my) ? mx : my;
            while (m >= (64'd1 << 30)) begin
                m >>= 1; mx >>= 1; my >>= 1;
            end
            while (m < (64'd1 << 29)) begin
                m <<= 1; mx <<= 1; my <<= 1;
            end
            len = floor_sqrt(mx * mx + my * my);
            ox = (mx * 16384 + len / 2) / len;
            oy = (my * 16384 + len / 2) / len;
            if (ox > 16384) ox = 16384;
            if (oy > 16384) oy = 16384;
            r.dir_x = (vx < 0) ? -16'(ox) : 16'(ox);
            r.dir_y = (vy < 0) ? -16'(oy) : 16'(oy);
            return r;
        endfunction

        function void note_point(egvf_pkg::t_in p);
            vec_q.push_back(field_vector(p));
        endfunction

        task report(string what, longint got, longint want);
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_vector(egvf_pkg::t_out r);
            egvf_pkg::t_out w;
            if (vec_q.size() == 0) begin
                report("unexpected result", 1, 0);
                return;
            end
            w = vec_q.pop_front();
            if (r.dir_x !== w.dir_x) report("dir_x", r.dir_x, w.dir_x);
            if (r.dir_y !== w.dir_y) report("dir_y", r.dir_y, w.dir_y);
            if (r.zero_field !== w.zero_field) report("zero_field", r.zero_field, w.zero_field);
        endtask
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    egvf_pkg::t_in                   i_in = '0;
    logic                            o_done;
    egvf_pkg::t_out                  o_result;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [egvf_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [egvf_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    field_scoreboard sb = new();

    ellipse_guidance_vector_field dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Results cannot be held off: take every strobed transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_vector(o_result);
    end

    // Write one register; hold valid until the channel takes it
    task write_reg(logic [egvf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
    endtask

    // Offer one point after a gap; keep start high across back-to-back points
    task send_point(logic [31:0] px, logic [31:0] py, int gap);
        egvf_pkg::t_in p;
        p.point_x = px;
        p.point_y = py;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in  <= p;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_point(p);
    endtask

    // Drop start, then hold until every expected vector has arrived
    task drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.vec_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // Write the full register set back to back, then drop valid
    task write_all(logic [31:0] cx, logic [31:0] cy, logic [15:0] c, logic [15:0] s,
                   logic [31:0] ia, logic [31:0] ib, logic d, logic [15:0] g);
        write_reg(egvf_pkg::CFG_CENTER_X, cx);
        write_reg(egvf_pkg::CFG_CENTER_Y, cy);
        write_reg(egvf_pkg::CFG_COS_ROT, {{16{c[15]}}, c});
        write_reg(egvf_pkg::CFG_SIN_ROT, {{16{s[15]}}, s});
        write_reg(egvf_pkg::CFG_INV_A_SQ, ia);
        write_reg(egvf_pkg::CFG_INV_B_SQ, ib);
        write_reg(egvf_pkg::CFG_DIRECTION, {31'b0, d});
        write_reg(egvf_pkg::CFG_GAIN, {16'b0, g});
        i_cfg_valid <= 1'b0;
    endtask

    function logic [31:0] near_coord(logic [31:0] centre);
        return centre + 32'($signed($urandom_range(0, 1048576)) - 524288);
    endfunction

    initial begin
        int          ang, gap;
        logic [15:0] c, s;
        logic [31:0] cx, cy, px, py;
        bit          no_idle;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: unit circle at the origin
        send_point(32'h0, 32'h0, 0);                  // centre, zero field
        send_point(32'h0001_0000, 32'h0, 0);          // on the circle
        send_point(32'h0, 32'hFFFF_0000, 1);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_point(32'h8000_0000, 32'h8000_0000, 2);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_point(32'h0000_8000, 32'h0000_8000, 0);  // inside
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 0);
        drain();

        // Extremes: rotation by 135 degrees scaled, steepest axes, top gain, reversed
        write_all(32'h8000_0000, 32'h7FFF_FFFF, 16'hC000, 16'h4000,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_point(32'h8000_FFFF, 32'h7FFF_0000, 3);
        send_point(32'h0, 32'h0, 0);
        drain();

        // Flat ellipse axes and zero gain: no normal, so no field at all
        write_all(32'h0, 32'h0, 16'h4000, 16'h0, 32'h0, 32'h0, 1'b0, 16'h0);
        send_point(32'h0003_0000, 32'hFFFE_0000, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
        drain();

        // Ellipse a=2, b=1 with half-turn rotation and unit gain
        write_all(32'h0001_0000, 32'hFFFF_0000, 16'hC000, 16'h0,
                  32'h2000_0000, 32'h8000_0000, 1'b1, 16'h0100);
        send_point(32'h0003_0000, 32'hFFFF_0000, 0);  // on the curve
        send_point(32'h0001_0000, 32'hFFFF_0000, 0);  // centre
        send_point(32'h0001_0000, 32'h0004_0000, 1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            ang = $urandom_range(0, 3);
            case (ang)
                0: begin c = 16'sd16384;  s = 16'sd0;      end
                1: begin c = 16'sd11585;  s = 16'sd11585;  end
                2: begin c = -16'sd16384; s = 16'sd0;      end
                default: begin
                    c = 16'($signed($urandom_range(0, 32768)) - 16384);
                    s = 16'($signed($urandom_range(0, 32768)) - 16384);
                end
            endcase
            cx = (ph % 3 == 2) ? $urandom : 32'($signed($urandom_range(0, 1310720)) - 655360);
            cy = (ph % 3 == 2) ? $urandom : 32'($signed($urandom_range(0, 1310720)) - 655360);
            write_all(cx, cy, c, s,
                      (ph == 5) ? $urandom : $urandom_range(32'h0080_0000, 32'h8000_0000),
                      (ph == 5) ? $urandom : $urandom_range(32'h0080_0000, 32'h8000_0000),
                      1'($urandom), (ph == 6) ? 16'($urandom) : 16'($urandom_range(0, 2048)));
            no_idle = (ph == 1 || ph == 4);
            for (int k = 0; k < 175; k++) begin
                if ($urandom_range(0, 9) < 8) begin
                    px = near_coord(cx);
                    py = near_coord(cy);
                end else begin
                    px = $urandom;
                    py = $urandom;
                end
                gap = no_idle ? 0 : $urandom_range(0, 9);
                // Pause once until the pipe is empty
                if (ph == 2 && k == 90) drain();
                send_point(px, py, gap);
            end
            drain();
        end

        if (sb.vec_q.size() != 0) sb.report("results missing", 0, sb.vec_q.size());
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
rtl/egvf_pkg.sv
rtl/ellipse_guidance_vector_field.sv
test/tb_ellipse_guidance_vector_field.sv
